[hdl/neighbour_proximity_table_defines.svh]
// ----------------------------------------------------------------------------
// neighbour proximity table assertion macros
// shared property forms for the table's concurrent checks
// ----------------------------------------------------------------------------
`ifndef NEIGHBOUR_PROXIMITY_TABLE_DEFINES_SVH
`define NEIGHBOUR_PROXIMITY_TABLE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define NPT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define NPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/npt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npt_pkg
// types and codes shared by the neighbour proximity table modules
// ----------------------------------------------------------------------------
package npt_pkg;

    typedef struct packed {
        logic              op;
        logic [15:0]       sender_id;
        logic signed [7:0] signal_strength;
        logic [31:0]       now_ticks;
    } item_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [3:0]  slot_index;
        logic [15:0] removed_mask;
    } result_t;

    typedef struct packed {
        logic signed [7:0] near_rssi_threshold;
        logic [7:0]        detect_seconds;
        logic [7:0]        absent_seconds;
    } cfg_t;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] near_since;
        logic [31:0] away_since;
    } entry_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic rd_en;
        logic decide;
    } dp_cmd_t;

    localparam logic OP_BEACON = 1'b0;
    localparam logic OP_SWEEP  = 1'b1;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_ADDED   = 3'd1;
    localparam logic [2:0] EV_NEAR    = 3'd2;
    localparam logic [2:0] EV_REPORT  = 3'd3;
    localparam logic [2:0] EV_AWAY    = 3'd4;
    localparam logic [2:0] EV_REMOVED = 3'd5;
    localparam logic [2:0] EV_FULL    = 3'd6;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_RSSI = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DETECT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ABSENT    = 2'd2;

    localparam logic signed [7:0] RST_NEAR_RSSI = -8'sd50;
    localparam logic [7:0]        RST_DETECT    = 8'd15;
    localparam logic [7:0]        RST_ABSENT    = 8'd30;

endpackage

[hdl/npt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npt_ctrl
// sequencer: load, scan every slot once, decide, then return to idle
// ----------------------------------------------------------------------------
module npt_ctrl #(
    parameter int ENTRIES = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output npt_pkg::dp_cmd_t cmd
);
    import npt_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_DECIDE,
        ST_FINISH
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    dp_cmd_t       cmd_reg, cmd_next;
    logic          load_now;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd_next   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN:
            begin
                cmd_next.rd_en = 1'b1;
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd_next.decide = 1'b1;
                state_next      = ST_FINISH;
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            cmd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            cmd_reg   <= cmd_next;
        end
    end

    // load strobes on the accepting edge, while the item is still presented
    assign load_now = (state_reg == ST_IDLE) && start;

    assign busy       = (state_reg != ST_IDLE);
    assign cmd.load   = load_now;
    assign cmd.rd_en  = cmd_reg.rd_en;
    assign cmd.decide = cmd_reg.decide;

endmodule

[hdl/npt_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npt_datapath
// entry memory, per-slot scan evaluation and the beacon decision
// ----------------------------------------------------------------------------
module npt_datapath #(
    parameter int ENTRIES          = 16,
    parameter int TICKS_PER_SECOND = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    input  npt_pkg::dp_cmd_t cmd,
    input  npt_pkg::cfg_t    cfg,
    input  npt_pkg::item_t   item,
    output logic             done,
    output npt_pkg::result_t result
);
    import npt_pkg::*;

    localparam int IW        = $clog2(ENTRIES);
    localparam int TPS_SHIFT = $clog2(TICKS_PER_SECOND);

    function automatic logic [31:0] secs_diff(input logic [31:0] now_t,
                                              input logic [31:0] then_t);
        return (now_t >> TPS_SHIFT) - (then_t >> TPS_SHIFT);
    endfunction

    entry_t               mem [ENTRIES];
    logic [ENTRIES-1:0]   vld_reg;

    item_t         item_reg;
    logic [IW-1:0] addr_reg;
    entry_t        rd_data_reg;
    logic          rd_vld_reg;
    logic          eval_vld_reg;
    logic [IW-1:0] eval_idx_reg;
    logic          found_reg;
    logic [IW-1:0] match_idx_reg;
    entry_t        match_ent_reg;
    logic          free_found_reg;
    logic [IW-1:0] free_idx_reg;
    logic [15:0]   mask_reg;
    logic          done_reg;
    result_t       result_reg;

    entry_t        rd_ent;
    logic          sweep_hit;
    logic          near_cond;
    logic [31:0]   then_t;
    logic [7:0]    lim;
    logic          expired;
    logic          dec_wr_en;
    logic [IW-1:0] dec_wr_idx;
    entry_t        dec_wr_ent;
    result_t       dec_res;
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    entry_t        wr_ent;

    // slot never written reads as free
    assign rd_ent = rd_vld_reg ? rd_data_reg : '0;

    assign sweep_hit = eval_vld_reg && (item_reg.op == OP_SWEEP)
                    && (rd_ent.id != '0) && (rd_ent.away_since != '0)
                    && (secs_diff(item_reg.now_ticks, rd_ent.away_since)
                        >= {24'd0, cfg.absent_seconds});

    assign near_cond = (item_reg.signal_strength >= cfg.near_rssi_threshold);
    assign then_t    = near_cond ? match_ent_reg.near_since : match_ent_reg.away_since;
    assign lim       = near_cond ? cfg.detect_seconds : cfg.absent_seconds;
    assign expired   = (secs_diff(item_reg.now_ticks, then_t) >= {24'd0, lim});

    always_comb
    begin
        dec_wr_en  = 1'b0;
        dec_wr_idx = match_idx_reg;
        dec_wr_ent = match_ent_reg;
        dec_res    = '0;
        if (item_reg.op == OP_SWEEP)
        begin
            dec_res.removed_mask = mask_reg;
            dec_res.event_res    = (mask_reg != '0) ? EV_REMOVED : EV_NONE;
        end
        else if (item_reg.sender_id == '0)
        begin
            dec_res = '0;
        end
        else if (found_reg)
        begin
            dec_res.slot_index = 4'(match_idx_reg);
            dec_wr_en          = 1'b1;
            if (!near_cond)
            begin
                dec_wr_ent.near_since = '0;
                if (match_ent_reg.away_since == '0)
                begin
                    dec_wr_ent.away_since = item_reg.now_ticks;
                    dec_res.event_res     = EV_AWAY;
                end
                else if (expired)
                begin
                    dec_wr_ent           = '0;
                    dec_res.removed_mask = 16'd1 << match_idx_reg;
                    dec_res.event_res    = EV_REMOVED;
                end
            end
            else
            begin
                dec_wr_ent.away_since = '0;
                if (match_ent_reg.near_since == '0)
                begin
                    dec_wr_ent.near_since = item_reg.now_ticks;
                    dec_res.event_res     = EV_NEAR;
                end
                else if (expired)
                begin
                    dec_res.event_res = EV_REPORT;
                end
            end
        end
        else if (near_cond)
        begin
            if (free_found_reg)
            begin
                dec_wr_en             = 1'b1;
                dec_wr_idx            = free_idx_reg;
                dec_wr_ent.id         = item_reg.sender_id;
                dec_wr_ent.near_since = item_reg.now_ticks;
                dec_wr_ent.away_since = '0;
                dec_res.slot_index    = 4'(free_idx_reg);
                dec_res.event_res     = EV_ADDED;
            end
            else
            begin
                dec_res.event_res = EV_FULL;
            end
        end
    end

    // sweep clears happen during the scan, the beacon write at decide
    assign wr_en  = sweep_hit || (cmd.decide && dec_wr_en);
    assign wr_idx = sweep_hit ? eval_idx_reg : dec_wr_idx;
    assign wr_ent = sweep_hit ? entry_t'('0) : dec_wr_ent;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_ent;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.rd_en)
        begin
            rd_vld_reg   <= vld_reg[addr_reg];
            eval_idx_reg <= addr_reg;
        end
        if (eval_vld_reg && !found_reg && (rd_ent.id == item_reg.sender_id))
        begin
            match_idx_reg <= eval_idx_reg;
            match_ent_reg <= rd_ent;
        end
        if (eval_vld_reg && !free_found_reg && (rd_ent.id == '0))
        begin
            free_idx_reg <= eval_idx_reg;
        end
        if (cmd.decide)
        begin
            result_reg <= dec_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg       <= '0;
            eval_vld_reg   <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            mask_reg       <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            eval_vld_reg <= cmd.rd_en;
            done_reg     <= cmd.decide;
            if (cmd.load)
            begin
                addr_reg       <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                mask_reg       <= '0;
            end
            else
            begin
                if (cmd.rd_en)
                begin
                    addr_reg <= addr_reg + 1'b1;
                end
                if (eval_vld_reg && (item_reg.op == OP_BEACON)
                    && (rd_ent.id == item_reg.sender_id))
                begin
                    found_reg <= 1'b1;
                end
                if (eval_vld_reg && (rd_ent.id == '0))
                begin
                    free_found_reg <= 1'b1;
                end
                if (sweep_hit)
                begin
                    mask_reg <= mask_reg | (16'd1 << eval_idx_reg);
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[hdl/neighbour_proximity_table.sv]
`timescale 1ns / 1ps
`include "neighbour_proximity_table_defines.svh"
// ----------------------------------------------------------------------------
// neighbour_proximity_table
// neighbour table tracking near and away times per sender, with report,
// removal and sweep events
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  -------   -----------------------   ---------------------------------
//  item in   start, busy               item   (op, sender, rssi, ticks)
//  result    done (one-cycle strobe)   result (event, slot, removed mask)
//  config    cfg_valid, cfg_ready      cfg_index, cfg_data
//
//  after accept, the scan reads one table slot per cycle through the entry
//  memory read port, then the decide step registers the beacon decision
//  busy is high from the cycle after accept and is already low when done is shown
//  reset clears the configuration to defaults and marks every slot free
//  the result receiver cannot stall; done lasts exactly one cycle
//  configuration is always ready and should only be written while idle
//
module neighbour_proximity_table #(
    parameter int ENTRIES          = 16,
    parameter int TICKS_PER_SECOND = 128
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // item channel
    input  logic                                 start,
    output logic                                 busy,
    input  npt_pkg::item_t                       item,
    // result channel
    output logic                                 done,
    output npt_pkg::result_t                     result,
    // configuration channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [npt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [7:0]                           cfg_data
);
    import npt_pkg::*;

    cfg_t    cfg_reg;
    dp_cmd_t cmd;

    // configuration registers, one write per handshake
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_rssi_threshold <= RST_NEAR_RSSI;
            cfg_reg.detect_seconds      <= RST_DETECT;
            cfg_reg.absent_seconds      <= RST_ABSENT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_NEAR_RSSI: cfg_reg.near_rssi_threshold <= cfg_data;
                REG_DETECT:    cfg_reg.detect_seconds      <= cfg_data;
                REG_ABSENT:    cfg_reg.absent_seconds      <= cfg_data;
                default:       ; // index past the register list is dropped
            endcase
        end
    end

    // sequencer: load, one slot read per cycle, decide
    npt_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    // entry memory, scan evaluation and result register
    npt_datapath #(
        .ENTRIES          (ENTRIES),
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .cfg    (cfg_reg),
        .item   (item),
        .done   (done),
        .result (result)
    );

    // an accepted item must make the block busy on the next cycle
    `NPT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    // done is a single-cycle strobe per item
    `NPT_ASSERT_NEXT(a_done_single, done, !done, "done held for more than one cycle")
    // a result only follows a busy period
    `NPT_ASSERT_NOW(a_done_after_busy, done, $past(busy), "done without a preceding busy cycle")
    // removed slots are only reported with the removed event
    `NPT_ASSERT_NOW(a_mask_event, done && (result.removed_mask != 16'd0),
        result.event_res == EV_REMOVED, "removed mask set without removed event")

endmodule
